### src/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types and constants of the packet frame receiver.
// ----------------------------------------------------------------------------
package pfr_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_MARKER = 1'b0,
    REG_OWN_ADDRESS  = 1'b1
  } cfg_reg_e;

  localparam int CFG_DATA_W = 8;

  // Register reset values.
  localparam logic [7:0] START_MARKER_RST = 8'h7E;
  localparam logic [1:0] OWN_ADDRESS_RST  = 2'd0;

  // Live configuration handed to the parser.
  typedef struct packed {
    logic [7:0] start_marker;
    logic [1:0] own_address;
  } pfr_cfg_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] byte_index;
    logic [1:0] origin;
    logic [3:0] length;
    logic [3:0] sequence_res;
    logic [3:0] ptype;
    logic       parity_ok;
    logic       last;
  } pfr_result_t;

endpackage

### src/pfr_if.sv
// ----------------------------------------------------------------------------
// pfr_if
// Channel interfaces: received byte stream, result stream, register writes.
// ----------------------------------------------------------------------------
interface pfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface pfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [3:0] byte_index;
  logic [1:0] origin;
  logic [3:0] length;
  logic [3:0] sequence_res;
  logic [3:0] ptype;
  logic       parity_ok;
  logic       last;

  modport source (output valid, output data_byte, output byte_index, output origin,
                  output length, output sequence_res, output ptype, output parity_ok,
                  output last, input ready);
  modport sink (input valid, input data_byte, input byte_index, input origin,
                input length, input sequence_res, input ptype, input parity_ok,
                input last, output ready);
endinterface

interface pfr_cfg_if import pfr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

### src/pfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// pfr_cfg_regs
// Configuration register file: start marker and own address.
// ----------------------------------------------------------------------------
module pfr_cfg_regs import pfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pfr_cfg_if.sink   cfg,
  output pfr_cfg_t  cfg_val
);

  logic [7:0] start_marker;
  logic [1:0] own_address;

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register writes by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RST;
      own_address  <= OWN_ADDRESS_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.index))
        REG_START_MARKER: start_marker <= cfg.wdata[7:0];
        REG_OWN_ADDRESS:  own_address  <= cfg.wdata[1:0];
        default: ;
      endcase
    end
  end

  assign cfg_val.start_marker = start_marker;
  assign cfg_val.own_address  = own_address;

endmodule

### src/pfr_parser.sv
// ----------------------------------------------------------------------------
// pfr_parser
// Frame parsing state machine with header latch, payload counter and parity.
// ----------------------------------------------------------------------------
module pfr_parser import pfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  input  pfr_cfg_t    cfg_val,
  output logic        res_valid,
  output pfr_result_t res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HDR1 = 2'd1,
    PH_HDR2 = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  phase_t     phase;
  logic [7:0] parity_acc;
  logic [3:0] count;
  logic [1:0] hdr_origin;
  logic [3:0] hdr_length;
  logic [7:0] hdr_seq_type;

  logic       in_body;
  logic       payload_beat;

  assign in_body      = accept && !frame_start && (phase == PH_BODY);
  assign payload_beat = count < hdr_length;

  // Result of the current beat: a payload byte or the closing frame summary.
  always_comb begin
    res_valid        = in_body;
    res.origin       = hdr_origin;
    res.length       = hdr_length;
    res.sequence_res = hdr_seq_type[7:4];
    res.ptype        = hdr_seq_type[3:0];
    if (payload_beat) begin
      res.data_byte  = rx_byte;
      res.byte_index = count;
      res.parity_ok  = 1'b0;
      res.last       = 1'b0;
    end else begin
      res.data_byte  = 8'd0;
      res.byte_index = hdr_length;
      res.parity_ok  = (rx_byte == parity_acc);
      res.last       = 1'b1;
    end
  end

  // Phase, header fields, count and running parity.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      parity_acc   <= 8'd0;
      count        <= 4'd0;
      hdr_origin   <= 2'd0;
      hdr_length   <= 4'd0;
      hdr_seq_type <= 8'd0;
    end else if (accept) begin
      if (frame_start) begin
        phase <= (rx_byte == cfg_val.start_marker) ? PH_HDR1 : PH_IDLE;
      end else begin
        unique case (phase)
          PH_HDR1: begin
            if (rx_byte[7:6] != cfg_val.own_address) begin
              phase <= PH_IDLE;
            end else begin
              hdr_origin <= rx_byte[5:4];
              hdr_length <= rx_byte[3:0];
              parity_acc <= {4'd0, rx_byte[3:0]};
              phase      <= PH_HDR2;
            end
          end
          PH_HDR2: begin
            hdr_seq_type <= rx_byte;
            parity_acc   <= parity_acc ^ rx_byte;
            count        <= 4'd0;
            phase        <= PH_BODY;
          end
          PH_BODY: begin
            if (payload_beat) begin
              parity_acc <= parity_acc ^ rx_byte;
              count      <= count + 4'd1;
            end else begin
              phase <= PH_IDLE;
            end
          end
          default: phase <= PH_IDLE;
        endcase
      end
    end
  end

  // The payload counter never runs past the latched length.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (count <= hdr_length))
    else $error("payload count exceeds frame length");

  // A closing result ends the frame.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.last) |=> (phase == PH_IDLE))
    else $error("frame still open after closing result");

  // Each payload result advances the counter by one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.last) |=> (count == $past(count) + 4'd1))
    else $error("payload counter did not advance");

endmodule

### src/pfr_out_reg.sv
// ----------------------------------------------------------------------------
// pfr_out_reg
// Result register between the parser and the result channel.
// ----------------------------------------------------------------------------
module pfr_out_reg import pfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  pfr_result_t res,
  output logic        space,
  pfr_out_if.source   res_out
);

  logic        valid;
  pfr_result_t data;

  // The register can take a new beat when empty or emptied this cycle.
  assign space = !valid || res_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      data <= res;
    end
  end

  assign res_out.valid        = valid;
  assign res_out.data_byte    = data.data_byte;
  assign res_out.byte_index   = data.byte_index;
  assign res_out.origin       = data.origin;
  assign res_out.length       = data.length;
  assign res_out.sequence_res = data.sequence_res;
  assign res_out.ptype        = data.ptype;
  assign res_out.parity_ok    = data.parity_ok;
  assign res_out.last         = data.last;

endmodule

### src/packet_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// packet_frame_receiver_top
// Parses a received byte stream into frames and emits payload and summary.
//
// Channels: rx_in carries one byte per beat with frame_start marking the
// first byte of a buffer; res_out carries one result beat per payload byte
// and a closing beat (last = 1) with header fields and the parity check on
// the parity byte; cfg writes the start marker (index 0) and own address
// (index 1) and is always ready.
// Throughput: one input beat per cycle unless stalled. Latency: a result
// appears on res_out the cycle after its byte is accepted, from the result
// register. Header bytes, dropped frames and padding give no result beat.
// Reset: the parser returns to idle, header fields and counters clear, the
// result register empties and the registers take marker 0x7E, address 0.
// Stall: while a result waits with res_out.ready low, rx_in.ready is low;
// it rises in the same cycle the waiting beat is taken.
// ----------------------------------------------------------------------------
module packet_frame_receiver_top import pfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  pfr_in_if.sink     rx_in,
  pfr_out_if.source  res_out,
  pfr_cfg_if.sink    cfg
);

  pfr_cfg_t    cfg_val;
  pfr_result_t res;
  logic        res_valid;
  logic        space;
  logic        accept;

  assign rx_in.ready = space;
  assign accept      = rx_in.valid && space;

  pfr_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_val (cfg_val)
  );

  pfr_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_in.rx_byte),
    .frame_start (rx_in.frame_start),
    .cfg_val     (cfg_val),
    .res_valid   (res_valid),
    .res         (res)
  );

  pfr_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (res_valid),
    .res     (res),
    .space   (space),
    .res_out (res_out)
  );

endmodule

### tb/tb_packet_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// tb_packet_frame_receiver_top
// Self-checking bench for the packet frame receiver.
//
// Frames are built on the fly and pushed byte by byte into rx_in. A small
// scoreboard tracks the parser state, works out the payload and closing beats
// that each accepted byte causes, and compares them in order against res_out.
// Both channels idle at random, the result side holds off once for a long
// stretch, and the start marker and own address change between phases.
// ----------------------------------------------------------------------------
module tb_packet_frame_receiver_top import pfr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 250;
  localparam int HOLD_AT_BEAT  = 400;
  localparam int PHASE_ITEMS   = 120;
  localparam int NUM_SETTINGS  = 6;

  // Parser position inside a frame.
  typedef enum logic [2:0] {
    PARSE_IDLE,
    PARSE_HDR_ADDR,
    PARSE_HDR_SEQ,
    PARSE_BODY
  } parse_state_e;

  // Frame shapes used by the random stimulus.
  typedef enum int {
    FR_GOOD,
    FR_BAD_PARITY,
    FR_WRONG_MARKER,
    FR_WRONG_DEST,
    FR_TRUNCATED,
    FR_NOISE
  } frame_kind_e;

  // Tracks the parser and holds the beats still owed by the block.
  class frame_scoreboard;
    logic [7:0]   marker;
    logic [1:0]   own_addr;
    parse_state_e state;
    logic [7:0]   parity;
    logic [3:0]   count;
    logic [1:0]   origin;
    logic [3:0]   len;
    logic [7:0]   seq_type;
    pfr_result_t  exp_results[$];
    int           errors;
    int           payload_seen;
    int           closing_seen;
    int           bad_parity_seen;

    function new();
      marker          = START_MARKER_RST;
      own_addr        = OWN_ADDRESS_RST;
      state           = PARSE_IDLE;
      parity          = '0;
      count           = '0;
      origin          = '0;
      len             = '0;
      seq_type        = '0;
      errors          = 0;
      payload_seen    = 0;
      closing_seen    = 0;
      bad_parity_seen = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [7:0] value);
      if (idx == REG_START_MARKER) begin
        marker = value;
      end else begin
        own_addr = value[1:0];
      end
    endfunction

    // Advance the parser by one accepted byte and queue any beat it causes.
    function void note_byte(logic [7:0] b, logic first);
      pfr_result_t r;
      if (first) begin
        state = (b == marker) ? PARSE_HDR_ADDR : PARSE_IDLE;
        return;
      end
      case (state)
        PARSE_HDR_ADDR: begin
          if (b[7:6] != own_addr) begin
            state = PARSE_IDLE;
          end else begin
            origin = b[5:4];
            len    = b[3:0];
            parity = {4'h0, b[3:0]};
            state  = PARSE_HDR_SEQ;
          end
        end
        PARSE_HDR_SEQ: begin
          seq_type = b;
          parity   = parity ^ b;
          count    = '0;
          state    = PARSE_BODY;
        end
        PARSE_BODY: begin
          r.origin       = origin;
          r.length       = len;
          r.sequence_res = seq_type[7:4];
          r.ptype        = seq_type[3:0];
          if (count < len) begin
            r.data_byte  = b;
            r.byte_index = count;
            r.parity_ok  = 1'b0;
            r.last       = 1'b0;
            parity       = parity ^ b;
            count        = count + 4'd1;
          end else begin
            r.data_byte  = '0;
            r.byte_index = len;
            r.parity_ok  = (b == parity);
            r.last       = 1'b1;
            state        = PARSE_IDLE;
          end
          exp_results.push_back(r);
        end
        default: begin
          state = PARSE_IDLE;
        end
      endcase
    endfunction

    function void field_ok(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one result beat against the oldest expectation.
    function void check_result(pfr_result_t got);
      pfr_result_t want;
      if (exp_results.size() == 0) begin
        $display("%0t: result beat expected none, got data_byte %0h index %0h last %0b",
                 $time, got.data_byte, got.byte_index, got.last);
        errors++;
        return;
      end
      want = exp_results.pop_front();
      field_ok("data_byte", want.data_byte, got.data_byte);
      field_ok("byte_index", want.byte_index, got.byte_index);
      field_ok("origin", want.origin, got.origin);
      field_ok("length", want.length, got.length);
      field_ok("sequence_res", want.sequence_res, got.sequence_res);
      field_ok("ptype", want.ptype, got.ptype);
      field_ok("parity_ok", want.parity_ok, got.parity_ok);
      field_ok("last", want.last, got.last);
      if (want.last) begin
        closing_seen++;
        if (!want.parity_ok) bad_parity_seen++;
      end else begin
        payload_seen++;
      end
    endfunction

    function int pending();
      return exp_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  pfr_in_if  rx_in ();
  pfr_out_if res_out ();
  pfr_cfg_if cfg ();

  packet_frame_receiver_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .rx_in   (rx_in),
    .res_out (res_out),
    .cfg     (cfg)
  );

  frame_scoreboard sb;
  pfr_result_t     seen_res;
  int              beats_in;
  int              frame_items;
  int              settings_used;
  int              cycles;
  int              stall_left;
  bit              rx_idle_en;
  bit              stall_en;
  logic            long_hold;

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap(bit en);
    int r;
    if (!en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side: check accepted beats, then choose ready for the next cycle.
  always @(posedge clk) begin
    if (!rst && res_out.valid && res_out.ready) begin
      seen_res = {res_out.data_byte, res_out.byte_index, res_out.origin, res_out.length,
                  res_out.sequence_res, res_out.ptype, res_out.parity_ok, res_out.last};
      sb.check_result(seen_res);
    end
    if (long_hold) begin
      res_out.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      res_out.ready <= 1'b0;
    end else begin
      stall_left = pick_gap(stall_en);
      res_out.ready <= (stall_left == 0);
    end
  end

  // Long hold-off on the result side while bytes keep coming.
  initial begin
    long_hold = 1'b0;
    wait (beats_in >= HOLD_AT_BEAT);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("packet_frame_receiver_top: mismatch");
      $finish;
    end
  end

  // Offer one byte after a random gap and wait for the beat to be taken.
  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    gap = pick_gap(rx_idle_en);
    if (gap > 0) begin
      rx_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_in.valid       <= 1'b1;
    rx_in.rx_byte     <= b;
    rx_in.frame_start <= first;
    do @(posedge clk); while (!rx_in.ready);
    sb.note_byte(b, first);
    beats_in++;
  endtask

  // Stop sending and wait until every owed beat has come out.
  task automatic drain();
    rx_in.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write both registers back to back; called only after a drain, with no beat owed.
  task automatic write_regs(input logic [7:0] marker_val, input logic [7:0] addr_word);
    cfg.valid <= 1'b1;
    cfg.index <= REG_START_MARKER;
    cfg.wdata <= marker_val;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(REG_START_MARKER, marker_val);
    cfg.index <= REG_OWN_ADDRESS;
    cfg.wdata <= addr_word;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(REG_OWN_ADDRESS, addr_word);
    cfg.valid <= 1'b0;
    settings_used++;
  endtask

  function automatic frame_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return FR_GOOD;
    if (r < 70) return FR_BAD_PARITY;
    if (r < 78) return FR_WRONG_MARKER;
    if (r < 86) return FR_WRONG_DEST;
    if (r < 94) return FR_TRUNCATED;
    return FR_NOISE;
  endfunction

  // Build one frame of the given shape and send it; skip_marker continues a
  // frame whose marker went out earlier.
  task automatic send_frame(input frame_kind_e kind, input bit skip_marker);
    logic [7:0] frame_q[$];
    logic [7:0] hdr;
    logic [7:0] seqtype;
    logic [7:0] par;
    logic [7:0] pb;
    logic [1:0] dest;
    logic [3:0] plen;
    int         npad;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'($urandom));
      return;
    end
    plen = 4'($urandom_range(0, 15));
    dest = sb.own_addr;
    if (kind == FR_WRONG_DEST) dest = dest + 2'($urandom_range(1, 3));
    hdr     = {dest, 2'($urandom_range(0, 3)), plen};
    seqtype = 8'($urandom);
    par     = {4'h0, plen} ^ seqtype;
    if (kind == FR_WRONG_MARKER) begin
      frame_q.push_back(sb.marker ^ 8'($urandom_range(1, 255)));
    end else begin
      frame_q.push_back(sb.marker);
    end
    frame_q.push_back(hdr);
    frame_q.push_back(seqtype);
    for (int i = 0; i < plen; i++) begin
      pb = 8'($urandom);
      par = par ^ pb;
      frame_q.push_back(pb);
    end
    if (kind == FR_BAD_PARITY) par = par ^ 8'($urandom_range(1, 255));
    frame_q.push_back(par);
    if (kind == FR_TRUNCATED) frame_q = frame_q[0:$urandom_range(1, frame_q.size() - 2)];
    for (int i = (skip_marker ? 1 : 0); i < frame_q.size(); i++) begin
      send_byte(frame_q[i], i == 0);
      frame_items++;
    end
    // Padding after a complete frame is ignored by the block.
    if ((kind == FR_GOOD || kind == FR_BAD_PARITY) && $urandom_range(0, 3) == 0) begin
      npad = $urandom_range(1, 3);
      repeat (npad) send_byte(8'($urandom), 1'b0);
    end
  endtask

  // Main sequence.
  initial begin
    logic [7:0] mk;
    logic [1:0] ad;
    int         target;

    sb                = new();
    beats_in          = 0;
    frame_items       = 0;
    settings_used     = 1;
    cycles            = 0;
    stall_left        = 0;
    rx_idle_en        = 1'b1;
    stall_en          = 1'b1;
    rst               = 1'b1;
    rx_in.valid       = 1'b0;
    rx_in.rx_byte     = '0;
    rx_in.frame_start = 1'b0;
    res_out.ready     = 1'b0;
    cfg.valid         = 1'b0;
    cfg.index         = REG_START_MARKER;
    cfg.wdata         = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset register values.
    send_byte(8'hFF, 1'b0);                  // stray byte while idle
    send_byte(8'h7E, 1'b1);                  // zero-length frame, good parity
    send_byte(8'h30, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);                  // padding
    send_byte(8'h7F, 1'b1);                  // wrong marker
    send_byte(8'h40, 1'b0);
    send_byte(8'h7E, 1'b1);                  // wrong destination
    send_byte(8'hC1, 1'b0);
    send_byte(8'h7E, 1'b1);                  // frame abandoned after one payload byte
    send_byte(8'h02, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h7E, 1'b1);                  // restart, then a bad parity byte
    send_byte(8'h22, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    drain();

    // Random part over several register settings.
    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      case (ph)
        0:       begin mk = 8'h00; ad = 2'd3; end
        1:       begin mk = 8'hFF; ad = 2'd0; end
        2:       begin mk = 8'h7E; ad = 2'd1; end
        3:       begin mk = 8'($urandom); ad = 2'd2; end
        default: begin mk = 8'($urandom); ad = 2'($urandom); end
      endcase
      // On odd phases the registers change between the marker and the header.
      if (ph % 2 == 1) begin
        send_byte(sb.marker, 1'b1);
        drain();
      end
      write_regs(mk, {6'($urandom), ad});
      if (ph % 2 == 1) send_frame(FR_GOOD, 1'b1);
      rx_idle_en = (ph != 2);
      stall_en   = (ph != 2 && ph != 4);
      target     = frame_items + PHASE_ITEMS;
      while (frame_items < target) send_frame(pick_kind(), 1'b0);
      drain();
    end

    $display("Run covered %0d input beats over %0d register settings: %0d payload beats,",
             beats_in, settings_used, sb.payload_seen);
    $display("%0d frame closings, %0d of them with a parity error.",
             sb.closing_seen, sb.bad_parity_seen);
    if (sb.errors == 0) begin
      $display("packet_frame_receiver_top: match");
    end else begin
      $display("packet_frame_receiver_top: mismatch");
    end
    $finish;
  end

endmodule

### packet_frame_receiver_top.f
src/pfr_pkg.sv
src/pfr_if.sv
src/pfr_cfg_regs.sv
src/pfr_parser.sv
src/pfr_out_reg.sv
src/packet_frame_receiver_top.sv
tb/tb_packet_frame_receiver_top.sv
